/* design/prst_pkg.sv */
// Shared constants and types for the point rigid scale transform.
package prst_pkg;

  localparam int unsigned COORD_WIDTH = 32;
  localparam int unsigned COEF_WIDTH  = 16;
  localparam int unsigned NUM_STAGES  = 5;
  localparam int unsigned CFG_INDEX_W = 3;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MATRIX_ROW0 = 3'd0,
    REG_MATRIX_ROW1 = 3'd1,
    REG_MATRIX_ROW2 = 3'd2,
    REG_SCALE       = 3'd3,
    REG_OFFSET_X    = 3'd4,
    REG_OFFSET_Y    = 3'd5,
    REG_OFFSET_Z    = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } stage_ctrl_t;

endpackage

/* design/prst_cfg.sv */
// Configuration registers for matrix rows, scale and translation.
module prst_cfg #(
  parameter int unsigned COORD_WIDTH = prst_pkg::COORD_WIDTH,
  parameter int unsigned COEF_WIDTH  = prst_pkg::COEF_WIDTH,
  localparam int unsigned ROW_W      = 3 * COEF_WIDTH,
  localparam int unsigned CFG_WIDTH  = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [prst_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [CFG_WIDTH-1:0]                cfg_data_i,
  output logic [ROW_W-1:0]                    row0_o,
  output logic [ROW_W-1:0]                    row1_o,
  output logic [ROW_W-1:0]                    row2_o,
  output logic signed [COORD_WIDTH-1:0]       scale_o,
  output logic signed [COORD_WIDTH-1:0]       offset_x_o,
  output logic signed [COORD_WIDTH-1:0]       offset_y_o,
  output logic signed [COORD_WIDTH-1:0]       offset_z_o
);

  logic [ROW_W-1:0]              row0_q, row1_q, row2_q;
  logic signed [COORD_WIDTH-1:0] scale_q, offset_x_q, offset_y_q, offset_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row0_q     <= ROW_W'(1) << (COEF_WIDTH - 2);
      row1_q     <= ROW_W'(1) << (2 * COEF_WIDTH - 2);
      row2_q     <= ROW_W'(1) << (3 * COEF_WIDTH - 2);
      scale_q    <= COORD_WIDTH'(1) << (COORD_WIDTH / 2);
      offset_x_q <= '0;
      offset_y_q <= '0;
      offset_z_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        prst_pkg::REG_MATRIX_ROW0: row0_q     <= cfg_data_i[ROW_W-1:0];
        prst_pkg::REG_MATRIX_ROW1: row1_q     <= cfg_data_i[ROW_W-1:0];
        prst_pkg::REG_MATRIX_ROW2: row2_q     <= cfg_data_i[ROW_W-1:0];
        prst_pkg::REG_SCALE:       scale_q    <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        prst_pkg::REG_OFFSET_X:    offset_x_q <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        prst_pkg::REG_OFFSET_Y:    offset_y_q <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        prst_pkg::REG_OFFSET_Z:    offset_z_q <= $signed(cfg_data_i[COORD_WIDTH-1:0]);
        default: ;
      endcase
    end
  end

  assign row0_o     = row0_q;
  assign row1_o     = row1_q;
  assign row2_o     = row2_q;
  assign scale_o    = scale_q;
  assign offset_x_o = offset_x_q;
  assign offset_y_o = offset_y_q;
  assign offset_z_o = offset_z_q;

endmodule

/* design/prst_axis.sv */
// Five-stage datapath that computes one output coordinate.
module prst_axis #(
  parameter int unsigned COORD_WIDTH = prst_pkg::COORD_WIDTH,
  parameter int unsigned COEF_WIDTH  = prst_pkg::COEF_WIDTH,
  localparam int unsigned ROW_W      = 3 * COEF_WIDTH
) (
  input  logic                          clk_i,
  input  prst_pkg::stage_ctrl_t         ctrl_i,
  input  logic signed [COORD_WIDTH-1:0] point_x_i,
  input  logic signed [COORD_WIDTH-1:0] point_y_i,
  input  logic signed [COORD_WIDTH-1:0] point_z_i,
  input  logic [ROW_W-1:0]              row_i,
  input  logic signed [COORD_WIDTH-1:0] scale_i,
  input  logic signed [COORD_WIDTH-1:0] offset_i,
  output logic signed [COORD_WIDTH-1:0] result_o,
  output logic                          ovf_o
);

  localparam int unsigned P1_W   = COORD_WIDTH + COEF_WIDTH;
  localparam int unsigned SUM_W  = P1_W + 1;
  localparam int unsigned RND_W  = COORD_WIDTH + 3;
  localparam int unsigned LOW_W  = RND_W / 2;
  localparam int unsigned HIGH_W = RND_W - LOW_W;
  localparam int unsigned PLO_W  = LOW_W + 1 + COORD_WIDTH;
  localparam int unsigned PHI_W  = HIGH_W + COORD_WIDTH;
  localparam int unsigned PROD_W = RND_W + COORD_WIDTH;
  localparam int unsigned SC_W   = PROD_W - COORD_WIDTH / 2;
  localparam int unsigned FIN_W  = SC_W + 1;

  localparam logic signed [SUM_W-1:0]  HALF_A = SUM_W'(1) <<< (COEF_WIDTH - 3);
  localparam logic signed [PROD_W-1:0] HALF_B = PROD_W'(1) <<< (COORD_WIDTH / 2 - 1);
  localparam logic signed [FIN_W-1:0]  MAX_V  = (FIN_W'(1) <<< (COORD_WIDTH - 1)) - FIN_W'(1);
  localparam logic signed [FIN_W-1:0]  MIN_V  = -(FIN_W'(1) <<< (COORD_WIDTH - 1));

  logic signed [COORD_WIDTH-1:0] pt [3];
  logic signed [COEF_WIDTH-1:0]  coef [3];
  logic signed [P1_W-1:0]        prod_q [3];
  logic signed [SUM_W-1:0]       sum;
  logic signed [RND_W-1:0]       rnd_q;
  logic signed [LOW_W:0]         rnd_lo;
  logic signed [HIGH_W-1:0]      rnd_hi;
  logic signed [PLO_W-1:0]       plo_q;
  logic signed [PHI_W-1:0]       phi_q;
  logic signed [PROD_W-1:0]      full;
  logic signed [SC_W-1:0]        scaled_q;
  logic signed [FIN_W-1:0]       total;
  logic signed [COORD_WIDTH-1:0] result_d, result_q;
  logic                          ovf_d, ovf_q;

  assign pt[0] = point_x_i;
  assign pt[1] = point_y_i;
  assign pt[2] = point_z_i;

  for (genvar j = 0; j < 3; j++) begin : g_coef
    assign coef[j] = $signed(row_i[j*COEF_WIDTH +: COEF_WIDTH]);

    always_ff @(posedge clk_i) begin
      if (ctrl_i.en[0]) begin
        prod_q[j] <= P1_W'(pt[j]) * P1_W'(coef[j]);
      end
    end
  end

  assign sum    = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]) + HALF_A;
  assign rnd_lo = $signed({1'b0, rnd_q[LOW_W-1:0]});
  assign rnd_hi = $signed(rnd_q[RND_W-1:LOW_W]);
  assign full   = (PROD_W'(phi_q) <<< LOW_W) + PROD_W'(plo_q) + HALF_B;
  assign total  = FIN_W'(scaled_q) + FIN_W'(offset_i);

  always_comb begin
    result_d = COORD_WIDTH'(total);
    ovf_d    = 1'b0;
    if (total > MAX_V) begin
      result_d = COORD_WIDTH'(MAX_V);
      ovf_d    = 1'b1;
    end else if (total < MIN_V) begin
      result_d = COORD_WIDTH'(MIN_V);
      ovf_d    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en[1]) begin
      rnd_q <= RND_W'(sum >>> (COEF_WIDTH - 2));
    end
    if (ctrl_i.en[2]) begin
      plo_q <= PLO_W'(rnd_lo) * PLO_W'(scale_i);
      phi_q <= PHI_W'(rnd_hi) * PHI_W'(scale_i);
    end
    if (ctrl_i.en[3]) begin
      scaled_q <= SC_W'(full >>> (COORD_WIDTH / 2));
    end
    if (ctrl_i.en[4]) begin
      result_q <= result_d;
      ovf_q    <= ovf_d;
    end
  end

  assign result_o = result_q;
  assign ovf_o    = ovf_q;

endmodule

/* design/prst_ctrl.sv */
// Valid and last tracking with per-stage enables for the elastic pipeline.
module prst_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  point_valid_i,
  input  logic                  point_last_i,
  output logic                  point_stall_o,
  output logic                  result_valid_o,
  output logic                  result_last_o,
  input  logic                  result_stall_i,
  output prst_pkg::stage_ctrl_t ctrl_o
);

  localparam int unsigned NS = prst_pkg::NUM_STAGES;

  logic [NS-1:0] valid_q, last_q;
  logic [NS:0]   ready;

  always_comb begin
    ready[NS] = !result_stall_i;
    for (int k = NS - 1; k >= 0; k--) begin
      ready[k] = !valid_q[k] || ready[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (ready[0]) begin
        valid_q[0] <= point_valid_i;
      end
      for (int k = 1; k < NS; k++) begin
        if (ready[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready[0]) begin
      last_q[0] <= point_last_i;
    end
    for (int k = 1; k < NS; k++) begin
      if (ready[k]) begin
        last_q[k] <= last_q[k-1];
      end
    end
  end

  assign ctrl_o.en      = ready[NS-1:0];
  assign point_stall_o  = !ready[0];
  assign result_valid_o = valid_q[NS-1];
  assign result_last_o  = last_q[NS-1];

  a_occupancy_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(valid_q) <= $past($countones(valid_q)) + 1) &&
    ($countones(valid_q) + 1 >= $past($countones(valid_q))))
    else $error("pipeline occupancy changed by more than one transaction");

  a_empty_entry_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[0] |-> !point_stall_o)
    else $error("input stalled while first stage is empty");

  a_free_output_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_stall_i |-> !point_stall_o)
    else $error("input stalled while output side is free");

  a_drain_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_stall_i && !valid_q[NS-2]) |=> !result_valid_o)
    else $error("result repeated after its transaction completed");

endmodule

/* design/point_rigid_scale_transform.sv */
// Throughput: one point per cycle while result_stall_i is low; each stage moves whenever its successor frees.
// Stages: coefficient products, row sum and rounding, split scale products,
// scale rounding, translation and saturation into the output register.
// Reset clears all stage valid bits and loads the identity matrix, unit scale
// and zero translation.
module point_rigid_scale_transform #(
  parameter int unsigned COORD_WIDTH = prst_pkg::COORD_WIDTH,
  parameter int unsigned COEF_WIDTH  = prst_pkg::COEF_WIDTH,
  localparam int unsigned ROW_W      = 3 * COEF_WIDTH,
  localparam int unsigned CFG_WIDTH  = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [prst_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_WIDTH-1:0]             cfg_data_i,
  input  logic                             point_valid_i,
  output logic                             point_stall_o,
  input  logic signed [COORD_WIDTH-1:0]    point_x_i,
  input  logic signed [COORD_WIDTH-1:0]    point_y_i,
  input  logic signed [COORD_WIDTH-1:0]    point_z_i,
  input  logic                             point_last_i,
  output logic                             result_valid_o,
  input  logic                             result_stall_i,
  output logic signed [COORD_WIDTH-1:0]    result_x_o,
  output logic signed [COORD_WIDTH-1:0]    result_y_o,
  output logic signed [COORD_WIDTH-1:0]    result_z_o,
  output logic                             overflow_flag_o,
  output logic                             result_last_o
);

  logic [ROW_W-1:0]              row0, row1, row2;
  logic signed [COORD_WIDTH-1:0] scale, offset_x, offset_y, offset_z;
  prst_pkg::stage_ctrl_t         ctrl;
  logic                          ovf_x, ovf_y, ovf_z;

  prst_cfg #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .row0_o     (row0),
    .row1_o     (row1),
    .row2_o     (row2),
    .scale_o    (scale),
    .offset_x_o (offset_x),
    .offset_y_o (offset_y),
    .offset_z_o (offset_z)
  );

  prst_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .point_valid_i (point_valid_i),
    .point_last_i  (point_last_i),
    .point_stall_o (point_stall_o),
    .result_valid_o(result_valid_o),
    .result_last_o (result_last_o),
    .result_stall_i(result_stall_i),
    .ctrl_o        (ctrl)
  );

  prst_axis #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_axis_x (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .point_z_i(point_z_i),
    .row_i    (row0),
    .scale_i  (scale),
    .offset_i (offset_x),
    .result_o (result_x_o),
    .ovf_o    (ovf_x)
  );

  prst_axis #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_axis_y (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .point_z_i(point_z_i),
    .row_i    (row1),
    .scale_i  (scale),
    .offset_i (offset_y),
    .result_o (result_y_o),
    .ovf_o    (ovf_y)
  );

  prst_axis #(
    .COORD_WIDTH(COORD_WIDTH),
    .COEF_WIDTH (COEF_WIDTH)
  ) u_axis_z (
    .clk_i    (clk_i),
    .ctrl_i   (ctrl),
    .point_x_i(point_x_i),
    .point_y_i(point_y_i),
    .point_z_i(point_z_i),
    .row_i    (row2),
    .scale_i  (scale),
    .offset_i (offset_z),
    .result_o (result_z_o),
    .ovf_o    (ovf_z)
  );

  assign overflow_flag_o = ovf_x | ovf_y | ovf_z;

endmodule

/* verif/tb_point_rigid_scale_transform.sv */
// Self-checking testbench for the point rigid scale transform with a queue-fed driver and monitor.
`timescale 1ns / 100ps

module tb_point_rigid_scale_transform;
  import prst_pkg::*;

  localparam int unsigned ROW_W = 3 * COEF_WIDTH;
  localparam int unsigned CFG_W = (ROW_W > COORD_WIDTH) ? ROW_W : COORD_WIDTH;
  localparam logic [CFG_INDEX_W-1:0] REG_NONE = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int IDLE_PCT = 21;

  typedef enum logic [1:0] {
    OP_POINT,
    OP_CONFIG,
    OP_DRAIN
  } op_kind_e;

  typedef struct {
    op_kind_e kind;
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic last;
    logic calm;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_W-1:0] data;
  } tb_op_t;

  typedef struct {
    logic signed [COORD_WIDTH-1:0] x;
    logic signed [COORD_WIDTH-1:0] y;
    logic signed [COORD_WIDTH-1:0] z;
    logic ovf;
    logic last;
  } point_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic point_valid_i = 1'b0;
  logic point_stall_o;
  logic signed [COORD_WIDTH-1:0] point_x_i = '0;
  logic signed [COORD_WIDTH-1:0] point_y_i = '0;
  logic signed [COORD_WIDTH-1:0] point_z_i = '0;
  logic point_last_i = 1'b0;
  logic result_valid_o;
  logic result_stall_i = 1'b0;
  logic signed [COORD_WIDTH-1:0] result_x_o;
  logic signed [COORD_WIDTH-1:0] result_y_o;
  logic signed [COORD_WIDTH-1:0] result_z_o;
  logic overflow_flag_o;
  logic result_last_o;

  logic calm_now = 1'b0;

  tb_op_t pending_ops[$];
  point_result_t transformed_q[$];

  logic [ROW_W-1:0] row_q[3];
  logic signed [COORD_WIDTH-1:0] scale_q;
  logic signed [COORD_WIDTH-1:0] offset_q[3];

  int mismatch_count = 0;
  int points_sent = 0;
  int results_seen = 0;
  int saturated_seen = 0;
  int set_ends_seen = 0;
  int reg_writes = 0;
  int drain_pauses = 0;
  int cycle_count = 0;

  point_rigid_scale_transform uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .point_valid_i  (point_valid_i),
    .point_stall_o  (point_stall_o),
    .point_x_i      (point_x_i),
    .point_y_i      (point_y_i),
    .point_z_i      (point_z_i),
    .point_last_i   (point_last_i),
    .result_valid_o (result_valid_o),
    .result_stall_i (result_stall_i),
    .result_x_o     (result_x_o),
    .result_y_o     (result_y_o),
    .result_z_o     (result_z_o),
    .overflow_flag_o(overflow_flag_o),
    .result_last_o  (result_last_o)
  );

  initial forever #10 clk_i = ~clk_i;

  function automatic logic signed [COORD_WIDTH-1:0] transform_axis(
    input logic [ROW_W-1:0] row,
    input logic signed [COORD_WIDTH-1:0] px,
    input logic signed [COORD_WIDTH-1:0] py,
    input logic signed [COORD_WIDTH-1:0] pz,
    input logic signed [COORD_WIDTH-1:0] offset,
    output logic sat);
    logic signed [127:0] acc;
    logic signed [127:0] bound_hi;
    logic signed [127:0] bound_lo;
    logic signed [COEF_WIDTH-1:0] c0;
    logic signed [COEF_WIDTH-1:0] c1;
    logic signed [COEF_WIDTH-1:0] c2;
    c0 = row[COEF_WIDTH-1:0];
    c1 = row[2*COEF_WIDTH-1:COEF_WIDTH];
    c2 = row[3*COEF_WIDTH-1:2*COEF_WIDTH];
    acc = px * c0 + py * c1 + pz * c2;
    acc = (acc + (128'sd1 << (COEF_WIDTH - 3))) >>> (COEF_WIDTH - 2);
    acc = acc * scale_q;
    acc = (acc + (128'sd1 << (COORD_WIDTH / 2 - 1))) >>> (COORD_WIDTH / 2);
    acc = acc + offset;
    bound_hi = (128'sd1 << (COORD_WIDTH - 1)) - 128'sd1;
    bound_lo = -(128'sd1 << (COORD_WIDTH - 1));
    sat = 1'b0;
    if (acc > bound_hi) begin
      sat = 1'b1;
      acc = bound_hi;
    end else if (acc < bound_lo) begin
      sat = 1'b1;
      acc = bound_lo;
    end
    return acc[COORD_WIDTH-1:0];
  endfunction

  function automatic point_result_t transform_point(
    input logic signed [COORD_WIDTH-1:0] px,
    input logic signed [COORD_WIDTH-1:0] py,
    input logic signed [COORD_WIDTH-1:0] pz,
    input logic last);
    point_result_t res;
    logic sx;
    logic sy;
    logic sz;
    res.x = transform_axis(row_q[0], px, py, pz, offset_q[0], sx);
    res.y = transform_axis(row_q[1], px, py, pz, offset_q[1], sy);
    res.z = transform_axis(row_q[2], px, py, pz, offset_q[2], sz);
    res.ovf = sx | sy | sz;
    res.last = last;
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic add_point(input logic signed [COORD_WIDTH-1:0] x,
                           input logic signed [COORD_WIDTH-1:0] y,
                           input logic signed [COORD_WIDTH-1:0] z,
                           input logic last, input logic calm);
    tb_op_t op;
    op = '{kind: OP_POINT, x: x, y: y, z: z, last: last, calm: calm,
           index: '0, data: '0};
    pending_ops.push_back(op);
  endtask

  task automatic add_config(input logic [CFG_INDEX_W-1:0] index,
                            input logic [CFG_W-1:0] data);
    tb_op_t op;
    op = '{kind: OP_CONFIG, x: '0, y: '0, z: '0, last: 1'b0, calm: 1'b0,
           index: index, data: data};
    pending_ops.push_back(op);
  endtask

  task automatic add_drain();
    tb_op_t op;
    op = '{kind: OP_DRAIN, x: '0, y: '0, z: '0, last: 1'b0, calm: 1'b0,
           index: '0, data: '0};
    pending_ops.push_back(op);
  endtask

  function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 32'sh7FFF_FFFF;
      1: return 32'sh8000_0000;
      2, 3: return $signed(32'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [COEF_WIDTH-1:0] rand_coef();
    case ($urandom_range(0, 9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'sh4000;
      4: return 16'shC000;
      5, 6: return $signed(16'($urandom_range(0, 16'h8000))) - 16'sh4000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] rand_word(input logic [COORD_WIDTH-1:0] value);
    logic [CFG_W-1:0] word;
    word = CFG_W'({$urandom, $urandom});
    word[COORD_WIDTH-1:0] = value;
    return word;
  endfunction

  function automatic logic signed [COORD_WIDTH-1:0] rand_scale();
    case ($urandom_range(0, 9))
      0: return 32'sh0000_0000;
      1, 2: return 32'sh0001_0000;
      3: return 32'sh7FFF_FFFF;
      4: return 32'sh8000_0000;
      5: return 32'shFFFF_0000;
      6, 7: return $signed(32'($urandom_range(0, 32'h0004_0000))) - 32'sh0002_0000;
      default: return $urandom;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic next_valid;
    logic next_we;
    tb_op_t head;
    if (!rst_ni) begin
      point_valid_i <= 1'b0;
      point_x_i <= '0;
      point_y_i <= '0;
      point_z_i <= '0;
      point_last_i <= 1'b0;
      cfg_we_i <= 1'b0;
      cfg_index_i <= '0;
      cfg_data_i <= '0;
      calm_now <= 1'b0;
      row_q[0] = ROW_W'(1) << (COEF_WIDTH - 2);
      row_q[1] = ROW_W'(1) << (2 * COEF_WIDTH - 2);
      row_q[2] = ROW_W'(1) << (3 * COEF_WIDTH - 2);
      scale_q = 32'sh0001_0000;
      offset_q[0] = '0;
      offset_q[1] = '0;
      offset_q[2] = '0;
    end else begin
      next_valid = point_valid_i;
      next_we = 1'b0;
      if (point_valid_i && !point_stall_o) begin
        transformed_q.push_back(transform_point(point_x_i, point_y_i, point_z_i,
                                                point_last_i));
        points_sent++;
        next_valid = 1'b0;
      end
      if (!next_valid && pending_ops.size() > 0) begin
        head = pending_ops[0];
        case (head.kind)
          OP_POINT: begin
            if (head.calm || $urandom_range(0, 99) >= IDLE_PCT) begin
              point_x_i <= head.x;
              point_y_i <= head.y;
              point_z_i <= head.z;
              point_last_i <= head.last;
              calm_now <= head.calm;
              next_valid = 1'b1;
              void'(pending_ops.pop_front());
            end
          end
          OP_CONFIG: begin
            if (transformed_q.size() == 0) begin
              cfg_index_i <= head.index;
              cfg_data_i <= head.data;
              next_we = 1'b1;
              case (head.index)
                REG_MATRIX_ROW0: row_q[0] = head.data[ROW_W-1:0];
                REG_MATRIX_ROW1: row_q[1] = head.data[ROW_W-1:0];
                REG_MATRIX_ROW2: row_q[2] = head.data[ROW_W-1:0];
                REG_SCALE: scale_q = head.data[COORD_WIDTH-1:0];
                REG_OFFSET_X: offset_q[0] = head.data[COORD_WIDTH-1:0];
                REG_OFFSET_Y: offset_q[1] = head.data[COORD_WIDTH-1:0];
                REG_OFFSET_Z: offset_q[2] = head.data[COORD_WIDTH-1:0];
                default: ;
              endcase
              reg_writes++;
              void'(pending_ops.pop_front());
            end
          end
          default: begin
            if (transformed_q.size() == 0) begin
              drain_pauses++;
              void'(pending_ops.pop_front());
            end
          end
        endcase
      end
      point_valid_i <= next_valid;
      cfg_we_i <= next_we;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    point_result_t exp_res;
    if (!rst_ni) begin
      result_stall_i <= 1'b0;
    end else begin
      if (result_valid_o && !result_stall_i) begin
        results_seen++;
        if (transformed_q.size() == 0) begin
          report_mismatch("result transaction with no expected point");
        end else begin
          exp_res = transformed_q.pop_front();
          if (result_x_o !== exp_res.x)
            report_mismatch($sformatf("x got %h expected %h", result_x_o, exp_res.x));
          if (result_y_o !== exp_res.y)
            report_mismatch($sformatf("y got %h expected %h", result_y_o, exp_res.y));
          if (result_z_o !== exp_res.z)
            report_mismatch($sformatf("z got %h expected %h", result_z_o, exp_res.z));
          if (overflow_flag_o !== exp_res.ovf)
            report_mismatch($sformatf("overflow got %b expected %b", overflow_flag_o,
                                      exp_res.ovf));
          if (result_last_o !== exp_res.last)
            report_mismatch($sformatf("last got %b expected %b", result_last_o,
                                      exp_res.last));
          if (exp_res.ovf)
            saturated_seen++;
          if (exp_res.last)
            set_ends_seen++;
        end
      end
      result_stall_i <= calm_now ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", cycle_count);
    $display("tb_point_rigid_scale_transform failed");
    $finish;
  end

  initial begin
    int set_left;
    logic last;
    add_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0, 1'b0);
    add_point(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0001, 1'b1, 1'b0);
    add_point(32'sh8000_0000, 32'sh7FFF_FFFF, 32'shFFFF_FFFF, 1'b0, 1'b0);
    add_point(32'sh1234_5678, -32'sh0ABC_DEF0, 32'sh0001_0000, 1'b1, 1'b0);

    // Half-LSB products check that ties round toward plus infinity.
    add_config(REG_MATRIX_ROW0, 48'h0000_0000_2000);
    add_config(REG_MATRIX_ROW1, 48'h0000_E000_0000);
    add_point(32'sh0000_0001, 32'sh0000_0001, 32'sh0000_0005, 1'b0, 1'b0);
    add_point(32'shFFFF_FFFF, 32'shFFFF_FFFF, 32'shFFFF_FFFB, 1'b0, 1'b0);
    add_point(32'sh0000_0003, 32'sh0000_0003, 32'sh0000_0000, 1'b1, 1'b0);

    add_config(REG_MATRIX_ROW0, 48'h7FFF_7FFF_7FFF);
    add_config(REG_MATRIX_ROW1, 48'h8000_8000_8000);
    add_config(REG_SCALE, 48'h0000_7FFF_FFFF);
    add_config(REG_OFFSET_X, 48'h0000_7FFF_FFFF);
    add_config(REG_OFFSET_Y, 48'h0000_8000_0000);
    add_point(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    add_point(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, 1'b0);
    add_point(32'sh0000_0000, 32'sh0000_0000, 32'sh0000_0000, 1'b0, 1'b0);
    add_point(32'sh0000_0001, 32'sh0000_0000, 32'sh0000_0000, 1'b1, 1'b0);

    // Zero scale leaves only the translation; the high data bits and the
    // unused register index must have no effect.
    add_config(REG_SCALE, 48'hFFFF_0000_0000);
    add_config(REG_OFFSET_Z, 48'hA5A5_1357_9BDF);
    add_config(REG_NONE, 48'hFFFF_FFFF_FFFF);
    add_point(rand_coord(), rand_coord(), rand_coord(), 1'b0, 1'b0);
    add_point(rand_coord(), rand_coord(), rand_coord(), 1'b1, 1'b0);

    add_config(REG_MATRIX_ROW0, 48'h0000_0000_4000);
    add_config(REG_MATRIX_ROW1, 48'h0000_4000_0000);
    add_config(REG_MATRIX_ROW2, 48'h4000_0000_0000);
    add_config(REG_SCALE, 48'h0000_8000_0000);
    add_point(32'sh0001_0000, 32'shFFFF_0000, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    add_point(32'sh8000_0000, 32'sh0000_0001, 32'sh0000_0000, 1'b1, 1'b0);

    for (int phase = 0; phase < 15; phase++) begin
      if (phase % 4 == 1) begin
        add_config(REG_MATRIX_ROW0, 48'h0000_0000_4000);
        add_config(REG_MATRIX_ROW1, 48'h0000_4000_0000);
        add_config(REG_MATRIX_ROW2, 48'h4000_0000_0000);
        add_config(REG_SCALE, rand_word(32'h0001_0000));
      end else begin
        add_config(REG_MATRIX_ROW0, rand_word({rand_coef(), rand_coef()}) |
                                    (CFG_W'(rand_coef()) << (2 * COEF_WIDTH)));
        add_config(REG_MATRIX_ROW1, {rand_coef(), rand_coef(), rand_coef()});
        add_config(REG_MATRIX_ROW2, {rand_coef(), rand_coef(), rand_coef()});
        add_config(REG_SCALE, rand_word(rand_scale()));
      end
      add_config(REG_OFFSET_X, rand_word(rand_coord()));
      add_config(REG_OFFSET_Y, rand_word(rand_coord()));
      add_config(REG_OFFSET_Z, rand_word(rand_coord()));
      if ($urandom_range(0, 3) == 0)
        add_config(REG_NONE, CFG_W'({$urandom, $urandom}));
      set_left = $urandom_range(1, 12);
      for (int n = 0; n < 100; n++) begin
        if ((phase == 3 || phase == 10) && n == 50)
          add_drain();
        if ($urandom_range(0, 19) == 0) begin
          last = 1'($urandom_range(0, 1));
        end else begin
          last = (set_left == 1);
          set_left = (set_left == 1) ? $urandom_range(1, 12) : set_left - 1;
        end
        add_point(rand_coord(), rand_coord(), rand_coord(), last, phase == 7);
      end
    end

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    wait (pending_ops.size() == 0 && !point_valid_i && transformed_q.size() == 0);
    repeat (4 * NUM_STAGES) @(posedge clk_i);

    $display("Run covered %0d points and %0d results, %0d of them saturated, %0d set ends.",
             points_sent, results_seen, saturated_seen, set_ends_seen);
    $display("It made %0d register writes and %0d drain pauses; %0d mismatches.",
             reg_writes, drain_pauses, mismatch_count);
    if (mismatch_count == 0 && transformed_q.size() == 0) begin
      $display("tb_point_rigid_scale_transform passed");
    end else begin
      $display("tb_point_rigid_scale_transform failed");
    end
    $finish;
  end

endmodule

/* point_rigid_scale_transform.f */
design/prst_pkg.sv
design/prst_cfg.sv
design/prst_axis.sv
design/prst_ctrl.sv
design/point_rigid_scale_transform.sv
verif/tb_point_rigid_scale_transform.sv
